// File: rtl/length_prefixed_message_deframer_unit_assert.svh
// Assertion macros shared by the deframer RTL files
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define LPMD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpmd assertion failed");

// next-cycle implication
`define LPMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpmd assertion failed");

`endif

// File: rtl/lpmd_pkg.sv
// Shared types and constants of the length-prefixed message deframer
package lpmd_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CNT_OUT_W       = 16;
  localparam int HDR_BYTES       = 5;
  localparam logic [31:0] MAX_SIZE_RST = 32'd4194304;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OVERSIZE = 2'd1;
  localparam logic [1:0] STAT_TRAILING = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           payload_byte;
    logic                 compressed;
    logic                 message_last;
    logic [CNT_OUT_W-1:0] message_count;
    logic [1:0]           status;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] n;
  } req_t;

endpackage

// File: rtl/lpmd_ifs.sv
// Channel interfaces: body input, result output, configuration write
interface lpmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       body_end;
  logic       no_data;

  modport source (output valid, data_byte, body_end, no_data, input ready);
  modport sink (input valid, data_byte, body_end, no_data, output ready);
endinterface

interface lpmd_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [7:0]                    payload_byte;
  logic                          compressed;
  logic                          message_last;
  logic [lpmd_pkg::CNT_OUT_W-1:0] message_count;
  logic [1:0]                    status;

  modport source (output valid, kind, payload_byte, compressed, message_last,
                  message_count, status, input ready);
  modport sink (input valid, kind, payload_byte, compressed, message_last,
                message_count, status, output ready);
endinterface

interface lpmd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_message_size;

  modport source (output valid, max_message_size, input ready);
  modport sink (input valid, max_message_size, output ready);
endinterface

// File: rtl/lpmd_core.sv
// Input register, framing state and per-item result generation
module lpmd_core #(
  parameter int COUNT_WIDTH = lpmd_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  lpmd_in_if.sink           in_ch,
  lpmd_cfg_if.sink          cfg_ch,
  input  logic              take,
  output lpmd_pkg::req_t    req,
  output lpmd_pkg::res_t    res0,
  output lpmd_pkg::res_t    res1
);

  `include "length_prefixed_message_deframer_unit_assert.svh"

  localparam int OW = lpmd_pkg::CNT_OUT_W;
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_ERROR   = 2'd2;
  localparam logic [2:0] HDR_LAST   = 3'(lpmd_pkg::HDR_BYTES - 1);

  logic                   s1_v_r, s1_v_nxt;
  logic [7:0]             s1_byte_r;
  logic                   s1_end_r, s1_none_r;
  logic [31:0]            max_r;
  logic [1:0]             phase_r, phase_nxt, phase_b;
  logic [2:0]             hdr_r, hdr_nxt, hdr_b;
  logic                   comp_r, comp_nxt;
  logic [31:0]            len_r, len_nxt, len_new;
  logic [31:0]            rem_r, rem_nxt, rem_dec;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc, cnt_b;
  logic [OW-1:0]          cnt_rep;
  logic                   bv;
  lpmd_pkg::res_t         bres, sres;
  logic [1:0]             sstat;
  logic                   in_acc;

  assign in_ch.ready  = !s1_v_r || take;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign s1_v_nxt     = in_acc ? 1'b1 : (take ? 1'b0 : s1_v_r);

  assign len_new = {len_r[23:0], s1_byte_r};
  assign rem_dec = rem_r - 32'd1;
  assign cnt_inc = (cnt_r != '1) ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    phase_b = phase_r;
    hdr_b   = hdr_r;
    comp_nxt = comp_r;
    len_nxt = len_r;
    rem_nxt = rem_r;
    cnt_b   = cnt_r;
    bv      = 1'b0;
    bres    = '0;
    if (!s1_none_r) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_r == 3'd0) begin
            comp_nxt = (s1_byte_r != 8'd0);
            len_nxt  = '0;
            hdr_b    = 3'd1;
          end else begin
            len_nxt = len_new;
            if (hdr_r == HDR_LAST) begin
              hdr_b = 3'd0;
              if (len_new > max_r) begin
                phase_b = PH_ERROR;
              end else if (len_new == 32'd0) begin
                cnt_b = cnt_inc;
                bv    = 1'b1;
                bres.kind         = lpmd_pkg::KIND_EMPTY;
                bres.compressed   = comp_r;
                bres.message_last = 1'b1;
              end else begin
                rem_nxt = len_new;
                phase_b = PH_PAYLOAD;
              end
            end else begin
              hdr_b = hdr_r + 3'd1;
            end
          end
        end
        PH_PAYLOAD: begin
          rem_nxt = rem_dec;
          bv      = 1'b1;
          bres.kind         = lpmd_pkg::KIND_BYTE;
          bres.payload_byte = s1_byte_r;
          bres.compressed   = comp_r;
          if (rem_dec == 32'd0) begin
            bres.message_last = 1'b1;
            cnt_b   = cnt_inc;
            phase_b = PH_HEADER;
          end
        end
        PH_ERROR: begin
        end
        default: begin
        end
      endcase
    end
    if (32'(cnt_b) > 32'({OW{1'b1}})) begin
      cnt_rep = '1;
    end else begin
      cnt_rep = OW'(cnt_b);
    end
    bres.message_count = cnt_rep;

    if (phase_b == PH_ERROR) begin
      sstat = lpmd_pkg::STAT_OVERSIZE;
    end else if (phase_b == PH_PAYLOAD || hdr_b != 3'd0) begin
      sstat = lpmd_pkg::STAT_TRAILING;
    end else begin
      sstat = lpmd_pkg::STAT_OK;
    end
    sres = '0;
    sres.kind          = lpmd_pkg::KIND_SUMMARY;
    sres.message_count = cnt_rep;
    sres.status        = sstat;

    phase_nxt = phase_b;
    hdr_nxt   = hdr_b;
    cnt_nxt   = cnt_b;
    if (s1_end_r) begin
      phase_nxt = PH_HEADER;
      hdr_nxt   = '0;
      comp_nxt  = 1'b0;
      len_nxt   = '0;
      rem_nxt   = '0;
      cnt_nxt   = '0;
    end

    req.valid = s1_v_r;
    req.n     = {1'b0, bv} + {1'b0, s1_end_r};
    res0      = bv ? bres : sres;
    res1      = sres;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      max_r   <= lpmd_pkg::MAX_SIZE_RST;
      phase_r <= PH_HEADER;
      hdr_r   <= '0;
      comp_r  <= 1'b0;
      len_r   <= '0;
      rem_r   <= '0;
      cnt_r   <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (cfg_ch.valid) begin
        max_r <= cfg_ch.max_message_size;
      end
      if (take) begin
        phase_r <= phase_nxt;
        hdr_r   <= hdr_nxt;
        comp_r  <= comp_nxt;
        len_r   <= len_nxt;
        rem_r   <= rem_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_ch.data_byte;
      s1_end_r  <= in_ch.body_end;
      s1_none_r <= in_ch.no_data;
    end
  end

  `LPMD_ASSERT_IMPL(a_payload_has_bytes, phase_r == PH_PAYLOAD, rem_r != 32'd0)
  `LPMD_ASSERT_IMPL(a_hdr_in_range, 1'b1, hdr_r <= HDR_LAST)
  `LPMD_ASSERT_NEXT(a_end_clears, take && s1_v_r && s1_end_r,
                    phase_r == PH_HEADER && hdr_r == 3'd0 && cnt_r == '0)

endmodule

// File: rtl/lpmd_outq.sv
// Two-entry result queue feeding the output channel
module lpmd_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  lpmd_pkg::req_t    req,
  input  lpmd_pkg::res_t    res0,
  input  lpmd_pkg::res_t    res1,
  output logic              take,
  lpmd_out_if.source        out_ch
);

  `include "length_prefixed_message_deframer_unit_assert.svh"

  logic [1:0]     occ_r, occ_nxt, base;
  lpmd_pkg::res_t q0_r, q0_nxt, q1_r, q1_nxt;
  logic           pop;

  assign pop  = (occ_r != 2'd0) && out_ch.ready;
  assign base = occ_r - {1'b0, pop};
  assign take = req.valid && ((base == 2'd0) || (base == 2'd1 && req.n <= 2'd1));

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    occ_nxt = base + (take ? req.n : 2'd0);
    if (pop) begin
      q0_nxt = q1_r;
    end
    if (take) begin
      if (base == 2'd0) begin
        q0_nxt = res0;
        q1_nxt = res1;
      end else begin
        q1_nxt = res0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_ch.valid         = (occ_r != 2'd0);
  assign out_ch.kind          = q0_r.kind;
  assign out_ch.payload_byte  = q0_r.payload_byte;
  assign out_ch.compressed    = q0_r.compressed;
  assign out_ch.message_last  = q0_r.message_last;
  assign out_ch.message_count = q0_r.message_count;
  assign out_ch.status        = q0_r.status;

  `LPMD_ASSERT_IMPL(a_occ_bound, 1'b1, occ_r != 2'd3)

endmodule

// File: rtl/length_prefixed_message_deframer_unit.sv
// Top level of the length-prefixed message deframer
// Takes one body byte per clock unless stalled. Each transfer is registered,
// decoded against the 5-byte header state in the same cycle, and its results
// (at most two: a payload byte or empty-message mark, then the end-of-body
// summary) go into a two-entry output queue. Input throughput is one transfer
// per cycle while the output is ready and no two-result stall occurs. An item
// that carries a payload byte or completes an empty message and also ends the
// body yields two results; the queue holds the extra one, and the input stalls
// only if another two-result item arrives before an item with no result or an
// idle input cycle has drained it. Output stalls back up into the input once
// the queue is full. max_message_size must be written through cfg_ch only
// while the block is idle, which it does not enforce. Reset sets it to 4194304.
module length_prefixed_message_deframer_unit #(
  parameter int COUNT_WIDTH = lpmd_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lpmd_in_if.sink     in_ch,
  lpmd_out_if.source  out_ch,
  lpmd_cfg_if.sink    cfg_ch
);

  lpmd_pkg::req_t req;
  lpmd_pkg::res_t res0, res1;
  logic           take;

  lpmd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .take   (take),
    .req    (req),
    .res0   (res0),
    .res1   (res1)
  );

  lpmd_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .res0   (res0),
    .res1   (res1),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule
